/* rtl/core/spla_pkg.sv */
// spla_pkg: shared types, codes and helpers for the sorted price level table
// no dependencies; imported by every module of the block
package spla_pkg;

    // default table depth
    localparam int MAX_LEVELS_DEF = 64;

    // request kinds
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NO_RANK = 2'd2;

    // request word
    typedef struct packed {
        logic        req_type;
        logic [31:0] price;
        logic [31:0] quantity;
        logic [5:0]  rank;
    } t_req;

    // response word
    typedef struct packed {
        logic [1:0]  status;
        logic        new_level;
        logic [31:0] level_price;
        logic [31:0] level_quantity;
        logic [6:0]  level_count;
    } t_rsp;

    // one table entry
    typedef struct packed {
        logic [31:0] price;
        logic [31:0] total;
    } t_level;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_SHRD,
        S_SHWR,
        S_RDAT,
        S_DONE
    } t_state;

    // level count as reported: low 7 bits
    function automatic logic [6:0] f_count7(input logic [31:0] v);
        return v[6:0];
    endfunction

endpackage

/* rtl/core/spla_level_mem.sv */
// spla_level_mem: level table storage, one write port, one registered read port
// depends on spla_pkg for the entry type
module spla_level_mem
    import spla_pkg::*;
#(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(MAX_LEVELS)-1:0] i_waddr,
    input  t_level                        i_wdata,
    input  logic [$clog2(MAX_LEVELS)-1:0] i_raddr,
    output t_level                        o_rdata
);

    t_level r_mem [MAX_LEVELS];
    t_level r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/spla_ctrl.sv */
// spla_ctrl: binary search, insertion shift and read sequencer over the level table
// depends on spla_pkg; drives spla_level_mem ports from the top level
module spla_ctrl
    import spla_pkg::*;
#(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  t_req                          i_req,
    output logic                          o_res_valid,
    input  logic                          i_res_take,
    output t_rsp                          o_res,
    output logic                          o_we,
    output logic [$clog2(MAX_LEVELS)-1:0] o_waddr,
    output t_level                        o_wdata,
    output logic [$clog2(MAX_LEVELS)-1:0] o_raddr,
    input  t_level                        i_rdata
);

    localparam int AW = $clog2(MAX_LEVELS);
    localparam int CW = $clog2(MAX_LEVELS + 1);

    t_state        r_state, n_state;
    t_req          r_req, n_req;
    t_rsp          r_res, n_res;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_used, n_used;
    logic [AW-1:0] r_mid, n_mid;
    logic [AW-1:0] r_fidx, n_fidx;
    logic [31:0]   r_ftot, n_ftot;
    logic          r_found, n_found;

    logic [CW-1:0] diff;
    logic [CW-1:0] mid_full;
    logic [AW-1:0] mid_c;
    logic [31:0]   rank32;
    logic          rank_ok;
    logic          is_full;
    logic [32:0]   sum_w;
    logic [31:0]   sum_sat;
    logic [CW-1:0] used_inc;
    logic [CW-1:0] i_dec;

    // search midpoint and helpers
    assign diff     = r_hi - r_lo;
    assign mid_full = r_lo + (diff >> 1);
    assign mid_c    = mid_full[AW-1:0];
    assign rank32   = 32'(i_req.rank);
    assign rank_ok  = rank32 < 32'(r_used);
    assign is_full  = r_used == CW'(MAX_LEVELS);
    assign sum_w    = {1'b0, r_ftot} + {1'b0, r_req.quantity};
    assign sum_sat  = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
    assign used_inc = r_used + CW'(1);
    assign i_dec    = r_i - CW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_req.req_type == REQ_ADD) begin
                        n_state = S_SRCH;
                    end else if (rank_ok) begin
                        n_state = S_RDAT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    n_state = S_CMP;
                end else if (r_found || is_full) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SHRD;
                end
            end
            S_CMP:  n_state = S_SRCH;
            S_SHRD: begin
                if (r_i > r_lo) begin
                    n_state = S_SHWR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHWR: n_state = S_SHRD;
            S_RDAT: n_state = S_DONE;
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_req       = r_req;
        n_res       = r_res;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_i         = r_i;
        n_used      = r_used;
        n_mid       = r_mid;
        n_fidx      = r_fidx;
        n_ftot      = r_ftot;
        n_found     = r_found;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_we        = 1'b0;
        o_waddr     = r_fidx;
        o_wdata     = i_rdata;
        o_raddr     = r_mid;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_raddr     = rank32[AW-1:0];
                if (i_req_valid) begin
                    n_req   = i_req;
                    n_lo    = '0;
                    n_hi    = r_used;
                    n_found = 1'b0;
                    n_res   = '{status: ST_NO_RANK, new_level: 1'b0, level_price: 32'd0,
                                level_quantity: 32'd0, level_count: f_count7(32'(r_used))};
                end
            end
            S_SRCH: begin
                // issue probe read, or settle once the range is empty
                o_raddr = mid_c;
                n_mid   = mid_c;
                if (!(r_lo < r_hi)) begin
                    if (r_found) begin
                        o_we    = 1'b1;
                        o_waddr = r_fidx;
                        o_wdata = '{price: r_req.price, total: sum_sat};
                        n_res   = '{status: ST_OK, new_level: 1'b0,
                                    level_price: r_req.price, level_quantity: sum_sat,
                                    level_count: f_count7(32'(r_used))};
                    end else if (is_full) begin
                        n_res = '{status: ST_FULL, new_level: 1'b0,
                                  level_price: r_req.price, level_quantity: 32'd0,
                                  level_count: f_count7(32'(r_used))};
                    end else begin
                        n_i = r_used;
                    end
                end
            end
            S_CMP: begin
                // narrow the range on the probed price
                if (i_rdata.price < r_req.price) begin
                    n_lo = CW'(r_mid) + CW'(1);
                end else begin
                    n_hi = CW'(r_mid);
                end
                if (i_rdata.price == r_req.price) begin
                    n_found = 1'b1;
                    n_fidx  = r_mid;
                    n_ftot  = i_rdata.total;
                end
            end
            S_SHRD: begin
                // read the entry below, or drop the new level into the gap
                o_raddr = i_dec[AW-1:0];
                if (!(r_i > r_lo)) begin
                    o_we    = 1'b1;
                    o_waddr = r_lo[AW-1:0];
                    o_wdata = '{price: r_req.price, total: r_req.quantity};
                    n_used  = used_inc;
                    n_res   = '{status: ST_OK, new_level: 1'b1,
                                level_price: r_req.price, level_quantity: r_req.quantity,
                                level_count: f_count7(32'(used_inc))};
                end
            end
            S_SHWR: begin
                // move that entry up by one
                o_we    = 1'b1;
                o_waddr = r_i[AW-1:0];
                o_wdata = i_rdata;
                n_i     = i_dec;
            end
            S_RDAT: begin
                n_res = '{status: ST_OK, new_level: 1'b0, level_price: i_rdata.price,
                          level_quantity: i_rdata.total,
                          level_count: f_count7(32'(r_used))};
            end
            S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_res   <= n_res;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_i     <= n_i;
        r_mid   <= n_mid;
        r_fidx  <= n_fidx;
        r_ftot  <= n_ftot;
        r_found <= n_found;
    end

    assign o_res = r_res;

endmodule

/* rtl/core/sorted_price_level_aggregator_core.sv */
// sorted_price_level_aggregator_core: top level of the sorted price level table
// depends on spla_pkg, spla_level_mem and spla_ctrl
//
// Usage:
//   Request channel i_req_valid / o_req_ready carries a t_req word: an add of
//   a quantity at a price, or a read of the level at an ascending rank.
//   Response channel o_rsp_valid / i_rsp_ready returns one t_rsp word per
//   request: status, new level flag, level price, saturated total, level count.
//   Levels sit in price order in one synchronous table memory. An add does a
//   binary search, each probe a read and then a compare, then either
//   updates the matching entry in place, drops the add if the table is full,
//   or shifts the higher entries up one at a time and writes the new level.
//   A read of an absent rank skips the table read. One request is in flight
//   at a time. Results go through an output register, so the next request
//   is taken while the previous word waits for the receiver; a stalled
//   receiver holds the word, and the block stalls only when a second
//   result is ready. Reset empties the table (level count to zero); no
//   clearing pass is needed.
module sorted_price_level_aggregator_core
    import spla_pkg::*;
#(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int AW = $clog2(MAX_LEVELS);

    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    t_level        wdata;
    t_level        rdata;
    logic          res_valid;
    logic          res_take;
    t_rsp          res;
    logic          r_out_valid, n_out_valid;
    t_rsp          r_out, n_out;

    // level table
    spla_level_mem #(
        .MAX_LEVELS(MAX_LEVELS)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // sequencer
    spla_ctrl #(
        .MAX_LEVELS(MAX_LEVELS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req      (i_req),
        .o_res_valid(res_valid),
        .i_res_take (res_take),
        .o_res      (res),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr    (raddr),
        .i_rdata    (rdata)
    );

    // output register: load when empty or draining
    assign res_take = res_valid && (!r_out_valid || i_rsp_ready);

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (res_take) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // one request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("request accepted while another is in flight");

    // a dropped add never reports a new level
    a_full_no_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status == ST_FULL) |-> !o_rsp.new_level)
        else $error("full status with new level set");

    // a new level is only reported with ok status
    a_new_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.new_level) |-> (o_rsp.status == ST_OK))
        else $error("new level with non-ok status");

endmodule

/* test/tb.sv */
// tb: self-checking bench for sorted_price_level_aggregator_core, adds and rank reads
// depends on spla_pkg and the core; keeps its own sorted level book to predict each word
module tb
    import spla_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEVELS  = MAX_LEVELS_DEF;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_WAIT  = 200;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic i_rsp_ready = 1'b0;
    t_req i_req       = '0;
    logic o_req_ready;
    logic o_rsp_valid;
    t_rsp o_rsp;

    // predicted book: ascending prices with their saturated totals
    logic [31:0] book_price [MAX_LEVELS];
    logic [31:0] book_total [MAX_LEVELS];
    int          book_count = 0;

    t_rsp pending_levels[$];
    int   mismatch_count = 0;
    int   idle_pct       = 0;
    int   cycle_count    = 0;

    sorted_price_level_aggregator_core #(
        .MAX_LEVELS(MAX_LEVELS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** sorted_price_level_aggregator_core: FAILED **");
            $finish;
        end
    end

    // apply one request to the book, return the word it should produce
    function automatic t_rsp predict_level(input t_req w);
        t_rsp        r;
        int          pos;
        int          i;
        logic [32:0] sum;
        r = '0;
        r.status = ST_OK;
        if (w.req_type == REQ_ADD) begin
            r.level_price = w.price;
            pos = 0;
            while (pos < book_count && book_price[pos] < w.price) pos++;
            if (pos < book_count && book_price[pos] == w.price) begin
                sum = {1'b0, book_total[pos]} + {1'b0, w.quantity};
                book_total[pos] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                r.level_quantity = book_total[pos];
            end else if (book_count >= MAX_LEVELS) begin
                r.status = ST_FULL;
            end else begin
                for (i = book_count; i > pos; i--) begin
                    book_price[i] = book_price[i - 1];
                    book_total[i] = book_total[i - 1];
                end
                book_price[pos] = w.price;
                book_total[pos] = w.quantity;
                book_count++;
                r.new_level      = 1'b1;
                r.level_quantity = w.quantity;
            end
        end else begin
            if (int'(w.rank) < book_count) begin
                r.level_price    = book_price[w.rank];
                r.level_quantity = book_total[w.rank];
            end else begin
                r.status = ST_NO_RANK;
            end
        end
        r.level_count = 7'(book_count);
        return r;
    endfunction

    function automatic t_req make_word(input logic kind, input logic [31:0] price,
                                       input logic [31:0] qty, input logic [5:0] rank);
        t_req w;
        w.req_type = kind;
        w.price    = price;
        w.quantity = qty;
        w.rank     = rank;
        return w;
    endfunction

    // random request biased toward existing levels, neighbors and big totals
    function automatic t_req random_word(input int read_pct, input int new_pct);
        t_req w;
        int   k;
        w.req_type = ($urandom_range(0, 99) < read_pct) ? REQ_READ : REQ_ADD;
        w.price    = $urandom;
        w.rank     = 6'($urandom_range(0, 63));
        case ($urandom_range(0, 3))
            0:       w.quantity = $urandom_range(0, 15);
            1:       w.quantity = $urandom;
            2:       w.quantity = 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: w.quantity = $urandom >> $urandom_range(0, 31);
        endcase
        if (w.req_type == REQ_READ) begin
            if (book_count > 0 && $urandom_range(0, 3) != 0)
                w.rank = 6'($urandom_range(0, book_count - 1));
        end else if (book_count > 0 && $urandom_range(0, 99) >= new_pct) begin
            w.price = book_price[$urandom_range(0, book_count - 1)];
        end else begin
            k = (book_count > 0) ? $urandom_range(0, book_count - 1) : 0;
            case ($urandom_range(0, 3))
                0: if (book_count > 0) w.price = book_price[k] + 32'd1;
                1: if (book_count > 0) w.price = book_price[k] - 32'd1;
                2: w.price = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                default: ;
            endcase
        end
        return w;
    endfunction

    // send one word, predict it at the accepting edge
    task automatic send_word(input t_req w);
        int gap;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 8);
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req       <= w;
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
        pending_levels.push_back(predict_level(w));
    endtask

    // hold off the sender until every outstanding word is back
    task automatic wait_all_results();
        i_req_valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
    endtask

    // receiver stalls in random bursts
    always begin
        @(posedge i_clk);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            i_rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_rsp_ready <= 1'b1;
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // compare each returned word with the oldest prediction
    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (pending_levels.size() == 0) begin
                $error("unexpected response word 0x%h", o_rsp);
                mismatch_count++;
            end else begin
                want = pending_levels.pop_front();
                check_field("status", 32'(want.status), 32'(o_rsp.status));
                check_field("new_level", 32'(want.new_level), 32'(o_rsp.new_level));
                check_field("level_price", want.level_price, o_rsp.level_price);
                check_field("level_quantity", want.level_quantity, o_rsp.level_quantity);
                check_field("level_count", 32'(want.level_count), 32'(o_rsp.level_count));
            end
        end
    end

    // reads on an empty table, ignored fields all ones
    task automatic test_empty_reads();
        idle_pct = 0;
        send_word(make_word(REQ_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0));
        send_word(make_word(REQ_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63));
    endtask

    // extreme prices, zero quantity, saturation and in-place updates
    task automatic test_extremes();
        idle_pct = 0;
        send_word(make_word(REQ_ADD, 32'h8000_0000, 32'd100, 6'd0));
        send_word(make_word(REQ_ADD, 32'h0000_0000, 32'd0, 6'd0));
        send_word(make_word(REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0));
        send_word(make_word(REQ_ADD, 32'hFFFF_FFFF, 32'd1, 6'd0));
        send_word(make_word(REQ_ADD, 32'h0000_0000, 32'hFFFF_FFFE, 6'd21));
        send_word(make_word(REQ_ADD, 32'h0000_0000, 32'd1, 6'd42));
        send_word(make_word(REQ_ADD, 32'h0000_0000, 32'd0, 6'd0));
        send_word(make_word(REQ_ADD, 32'h7FFF_FFFF, 32'd7, 6'd63));
        send_word(make_word(REQ_ADD, 32'h8000_0001, 32'h5555_5555, 6'd0));
        for (int r = 0; r <= 5; r++)
            send_word(make_word(REQ_READ, 32'h0, 32'h0, 6'(r)));
        send_word(make_word(REQ_READ, 32'hAAAA_AAAA, 32'h5555_5555, 6'd63));
        wait_all_results();
    endtask

    // random traffic while the table grows toward full
    task automatic test_fill_table();
        int n;
        n = 0;
        idle_pct = 20;
        while (book_count < MAX_LEVELS && n < 1000) begin
            send_word(random_word(25, 20));
            n++;
        end
        // top up with fresh prices if random traffic did not get there
        while (book_count < MAX_LEVELS)
            send_word(make_word(REQ_ADD, $urandom, $urandom, 6'($urandom_range(0, 63))));
        wait_all_results();
    endtask

    // full table: updates, dropped adds, reads over every rank
    task automatic test_full_table();
        for (int n = 0; n < 950; n++) begin
            idle_pct = ((n / 150) % 2 == 0) ? 20 : 0;
            send_word(random_word(30, 30));
        end
        wait_all_results();
    endtask

    // closing stretch with no idling on either side
    task automatic test_quiet_stream();
        idle_pct = 0;
        for (int n = 0; n < 300; n++)
            send_word(random_word(30, 25));
        wait_all_results();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_reads();
        test_extremes();
        test_fill_table();
        test_full_table();
        test_quiet_stream();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && pending_levels.size() == 0) begin
            $display("** sorted_price_level_aggregator_core: PASSED **");
        end else begin
            $display("** sorted_price_level_aggregator_core: FAILED **");
        end
        $finish;
    end

endmodule
